>>> src/bss_pkg.sv
// Package for the bounded substring search block: sizes, register indexes
// and the payload and control structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bss_pkg;

    // Sizes
    localparam int PATTERN_MAX = 16;
    localparam int OFFSET_BITS = 16;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W       = $clog2(PATTERN_MAX);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int LIMIT_W     = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HI  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 3'd3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

    // Input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_buffer;
        logic       end_of_buffer;
    } t_in;

    // Result item
    typedef struct packed {
        logic                   match_found;
        logic [OFFSET_BITS-1:0] match_offset;
    } t_out;

    // Derived settings handed from the register file to the datapath
    typedef struct packed {
        logic                             busy;
        logic [LEN_W-1:0]                 len;
        logic [LIMIT_W-1:0]               limit;
        logic [PATTERN_MAX-1:0]           use_mask;
        logic [PATTERN_MAX-1:0][7:0]      align;
    } t_prep;

endpackage

`default_nettype wire

>>> src/bss_cell.sv
// One window cell: holds one recent buffer byte, passes it on to the next
// cell on each transfer and compares it against its aligned pattern byte.
// Depends on bss_pkg (style only).
`timescale 1ns / 1ps
`default_nettype none

module bss_cell (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_shift,
    input  wire logic [7:0] i_byte,
    input  wire logic [7:0] i_pat,
    input  wire logic       i_use,
    output logic [7:0]      o_byte,
    output logic            o_hit
);
    import bss_pkg::*;

    logic [7:0] r_byte;

    // Window byte, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    // Unused cells always agree
    assign o_hit  = !i_use || (r_byte == i_pat);
    assign o_byte = r_byte;

endmodule

`default_nettype wire

>>> src/bss_prep.sv
// Configuration registers and derived settings: effective pattern length
// and the pattern bytes aligned to the window cells. Depends on bss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bss_prep (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic [bss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output bss_pkg::t_prep                     o_prep
);
    import bss_pkg::*;

    logic [63:0]                  r_pat_lo;
    logic [63:0]                  r_pat_hi;
    logic [LEN_W-1:0]             r_plen;
    logic [LIMIT_W-1:0]           r_limit;
    logic                         r_busy;
    logic [LEN_W-1:0]             r_len;
    logic [LEN_W-1:0]             n_len;
    logic [PATTERN_MAX-1:0]       r_use;
    logic [PATTERN_MAX-1:0]       n_use;
    logic [PATTERN_MAX-1:0][7:0]  r_align;
    logic [PATTERN_MAX-1:0][7:0]  n_align;
    logic [15:0][7:0]             pat_bytes;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_plen   <= '0;
            r_limit  <= LIMIT_RESET;
            r_busy   <= 1'b1;
        end else begin
            r_busy <= i_cfg_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_PAT_LO:  r_pat_lo <= i_cfg_data;
                    REG_PAT_HI:  r_pat_hi <= i_cfg_data;
                    REG_PAT_LEN: r_plen   <= i_cfg_data[LEN_W-1:0];
                    REG_LIMIT:   r_limit  <= i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign pat_bytes = {r_pat_hi, r_pat_lo};

    // Effective length: min of length, max, limit and leading nonzero bytes
    always_comb begin
        logic [LEN_W-1:0] cap;
        logic             seen_zero;
        cap       = (r_plen > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : r_plen;
        if (LIMIT_W'(cap) > r_limit) begin
            cap = r_limit[LEN_W-1:0];
        end
        seen_zero = 1'b0;
        n_len     = cap;
        for (int m = 0; m < PATTERN_MAX; m++) begin
            if (!seen_zero && pat_bytes[m] == 8'd0) begin
                seen_zero = 1'b1;
                if (LEN_W'(m) < cap) begin
                    n_len = LEN_W'(m);
                end
            end
        end
    end

    // Cell k compares against pattern byte len-1-k
    always_comb begin
        logic [LEN_W-1:0] pidx;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            pidx       = r_len - LEN_W'(1) - LEN_W'(k);
            n_use[k]   = LEN_W'(k) < r_len;
            n_align[k] = pat_bytes[pidx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_use   <= n_use;
        r_align <= n_align;
    end

    assign o_prep.busy     = r_busy;
    assign o_prep.len      = r_len;
    assign o_prep.limit    = r_limit;
    assign o_prep.use_mask = r_use;
    assign o_prep.align    = r_align;

endmodule

`default_nettype wire

>>> src/bounded_substring_search.sv
// Bounded substring search: one byte per cycle through a row of window cells,
// one result per buffer (match offset or not found). Depends on bss_pkg.
// Pipeline: the deciding byte is registered in stage 1, the result in the output register.
// Throughput: one byte per cycle; stalls on output back-pressure, during each
// configuration write and in the cycle after it (derived settings reload).
// Reset: synchronous active-low; the input stays closed until the busy flag set by reset clears.
`timescale 1ns / 1ps
`default_nettype none

module bounded_substring_search (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire bss_pkg::t_in                  i_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output bss_pkg::t_out                      o_out,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [bss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bss_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bss_pkg::*;

    t_prep                        prep;
    logic                         in_xfer;
    logic                         advance;
    logic [PATTERN_MAX-1:0][7:0]  win;
    logic [PATTERN_MAX-1:0]       hits;

    logic [OFFSET_BITS-1:0]       r_pos;
    logic [OFFSET_BITS-1:0]       n_pos;
    logic [OFFSET_BITS:0]         n_count;
    logic                         r_s1_valid;
    logic                         r_s1_first;
    logic                         r_s1_last;
    logic                         r_s1_zero;
    logic [OFFSET_BITS:0]         r_s1_count;
    logic                         r_done;
    logic                         r_out_valid;
    t_out                         r_out;

    logic                         done_eff;
    logic                         emit;
    t_out                         n_out;

    bss_prep u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_prep      (prep)
    );

    assign o_cfg_ready = 1'b1;
    assign advance     = !r_out_valid || i_out_ready;
    assign o_in_ready  = (!r_s1_valid || advance) && !prep.busy && !i_cfg_valid;
    assign in_xfer     = i_in_valid && o_in_ready;

    // Window cells; a new buffer clears the older bytes
    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        logic [7:0] feed;
        if (k == 0) begin : g_head
            assign feed = i_in.data_byte;
        end else begin : g_body
            assign feed = i_in.first_of_buffer ? 8'd0 : win[k-1];
        end
        bss_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (in_xfer),
            .i_byte  (feed),
            .i_pat   (prep.align[k]),
            .i_use   (prep.use_mask[k]),
            .o_byte  (win[k]),
            .o_hit   (hits[k])
        );
    end

    // Byte position, saturating
    always_comb begin
        logic [OFFSET_BITS-1:0] base;
        base    = i_in.first_of_buffer ? '0 : r_pos;
        n_count = {1'b0, base} + (OFFSET_BITS+1)'(1);
        n_pos   = (&base) ? base : n_count[OFFSET_BITS-1:0];
    end

    // Stage 1: item control alongside the shifted window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_pos      <= '0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
            r_pos      <= n_pos;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_first <= i_in.first_of_buffer;
            r_s1_last  <= i_in.end_of_buffer;
            r_s1_zero  <= (i_in.data_byte == 8'd0);
            r_s1_count <= n_count;
        end
    end

    // Decision on the window of the stage 1 item
    always_comb begin
        logic [OFFSET_BITS:0] len_ext;
        logic [OFFSET_BITS:0] lim_ext;
        logic [OFFSET_BITS:0] offs;
        len_ext  = (OFFSET_BITS+1)'(prep.len);
        lim_ext  = (OFFSET_BITS+1)'(prep.limit);
        offs     = r_s1_count - len_ext;
        done_eff = r_s1_first ? 1'b0 : r_done;
        emit     = 1'b0;
        n_out    = '0;
        if (prep.len == '0) begin
            emit              = 1'b1;
            n_out.match_found = 1'b1;
        end else if (r_s1_zero) begin
            emit = 1'b1;
        end else if (r_s1_count >= len_ext && r_s1_count <= lim_ext && (&hits)) begin
            emit               = 1'b1;
            n_out.match_found  = 1'b1;
            n_out.match_offset = offs[OFFSET_BITS-1:0];
        end else if (r_s1_count >= lim_ext || r_s1_last) begin
            emit = 1'b1;
        end
        if (done_eff) begin
            emit = 1'b0;
        end
    end

    // Search-done flag and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid && emit;
            if (r_s1_valid) begin
                r_done <= done_eff || emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid && emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

>>> src/bss_checker.sv
// Port-level checks for bounded_substring_search and the bind that attaches them.
// Depends on bss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bss_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          o_in_ready,
    input  wire bss_pkg::t_in                  i_in,
    input  wire logic                          o_out_valid,
    input  wire logic                          i_out_ready,
    input  wire bss_pkg::t_out                 o_out,
    input  wire logic                          i_cfg_valid,
    input  wire logic                          o_cfg_ready
);
    import bss_pkg::*;

    // A held result does not change until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // Not found always carries a zero offset
    a_zero_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.match_found |-> o_out.match_offset == '0)
        else $error("nonzero offset on not found");

    // Input is held off in the cycle after a register write
    a_cfg_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> !o_in_ready)
        else $error("input taken right after register write");

    // Reset empties the output and closes the input
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("output or input open right after reset");

    // A new result needs an earlier input transfer or an earlier stalled result
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2) || $past(o_out_valid, 2))
        else $error("result without a preceding input transfer");

endmodule

bind bounded_substring_search bss_checker u_bss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready)
);

`default_nettype wire

>>> sim/tb_bounded_substring_search.sv
`timescale 1ns / 1ps
// Testbench for bounded_substring_search: a directed table, then random buffers
// checked against a behavioral search predictor. Depends on bss_pkg and the block.
module tb_bounded_substring_search;
    import bss_pkg::*;

    localparam int WINDOW         = 16;
    localparam int RESET_CYCLES   = 11;
    localparam int GAP_MAX        = 17;
    localparam int SETTLE_CYCLES  = 6;
    localparam int DRAIN_CYCLES   = 12;
    localparam int STALL_LIMIT    = 2000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int PHASES         = 9;
    localparam int PHASE_BYTES    = 45;
    localparam int PRESSURE_PHASE = 4;
    localparam logic [CFG_IDX_W-1:0]   REG_SPARE_LO = 3'd4;
    localparam logic [CFG_IDX_W-1:0]   REG_SPARE_HI = 3'd7;
    localparam logic [OFFSET_BITS-1:0] POS_SAT      = '1;

    typedef enum logic {ROW_SETUP, ROW_BYTE} t_row_kind;

    // One line of the directed script: a full register setup or one byte
    typedef struct packed {
        t_row_kind    kind;
        logic [63:0]  pat_lo;
        logic [63:0]  pat_hi;
        logic [4:0]   pat_len;
        logic [15:0]  limit;
        t_in          item;
        logic         typed;
        t_out         want;
    } t_row;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in                   in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out                  out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor copy of the registers and the search state
    logic [63:0]            cfg_pat_lo;
    logic [63:0]            cfg_pat_hi;
    logic [4:0]             cfg_pat_len;
    logic [15:0]            cfg_limit;
    logic [7:0]             recent [WINDOW];
    logic [OFFSET_BITS-1:0] position;
    bit                     buffer_closed;

    t_out match_queue [$];
    t_row script [$];
    int   error_count  = 0;
    int   sent_bytes   = 0;
    int   quiet_cycles = 0;
    bit   quiet_idle   = 1'b0;
    bit   rx_hold_req  = 1'b0;

    bounded_substring_search dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("%0t: mismatch: %s", $time, what);
    endtask

    function automatic logic [7:0] pattern_at(input int m);
        if (m < 8) return cfg_pat_lo[m*8 +: 8];
        return cfg_pat_hi[(m-8)*8 +: 8];
    endfunction

    // Pattern length in use: register value, capped, cut at the first zero byte
    function automatic int live_length();
        int len;
        len = int'(cfg_pat_len);
        if (len > WINDOW) len = WINDOW;
        if (len > int'(cfg_limit)) len = int'(cfg_limit);
        for (int m = 0; m < len; m++) begin
            if (pattern_at(m) == 8'h00) return m;
        end
        return len;
    endfunction

    // Advance the search by one byte; returns 1 when the byte closes the buffer
    function automatic bit search_step(input t_in item, output t_out res);
        int  count;
        int  len;
        bit  same;
        res = '0;
        if (item.first_of_buffer) begin
            recent = '{default: 8'h00};
            position = '0;
            buffer_closed = 1'b0;
        end
        if (buffer_closed) return 1'b0;
        for (int k = WINDOW - 1; k > 0; k--) recent[k] = recent[k-1];
        recent[0] = item.data_byte;
        count = int'(position) + 1;
        if (position < POS_SAT) position++;
        len = live_length();
        buffer_closed = 1'b1;
        if (len == 0) begin
            res.match_found = 1'b1;
            return 1'b1;
        end
        if (item.data_byte == 8'h00) return 1'b1;
        if (count >= len && count <= int'(cfg_limit)) begin
            same = 1'b1;
            for (int m = 0; m < len; m++) begin
                if (recent[len-1-m] != pattern_at(m)) same = 1'b0;
            end
            if (same) begin
                res.match_found  = 1'b1;
                res.match_offset = OFFSET_BITS'(count - len);
                return 1'b1;
            end
        end
        if (count >= int'(cfg_limit) || item.end_of_buffer) return 1'b1;
        buffer_closed = 1'b0;
        return 1'b0;
    endfunction

    // Mostly a three-letter alphabet so matches happen; now and then any byte
    function automatic logic [7:0] random_text_byte();
        int pick;
        pick = $urandom_range(0, 39);
        if (pick == 0) return 8'h00;
        if (pick <= 3) return 8'($urandom_range(0, 255));
        return 8'h41 + 8'($urandom_range(0, 2));
    endfunction

    // Input transfer: optional gap, then hold valid until accepted
    task automatic offer_byte(input t_in item);
        int gap;
        gap = quiet_idle ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_item  <= item;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic feed_byte(input t_in item, input logic typed, input t_out want);
        bit   hit;
        t_out got;
        hit  = search_step(item, got);
        if (typed) begin
            if (!hit || got != want) report_mismatch("directed row disagrees with predictor");
            match_queue.push_back(want);
        end else if (hit) begin
            match_queue.push_back(got);
        end
        sent_bytes++;
        offer_byte(item);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Wait for the block to drain, then load a complete search setting.
    // Upper data bits of the narrow registers are random: they must be dropped.
    task automatic program_search(input logic [63:0] lo, input logic [63:0] hi,
                                  input logic [4:0] len, input logic [15:0] limit);
        in_valid <= 1'b0;
        while (match_queue.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_PAT_LO, lo);
        write_reg(REG_PAT_HI, hi);
        write_reg(REG_PAT_LEN, {27'($urandom), $urandom, len});
        write_reg(REG_LIMIT, {$urandom, 16'($urandom), limit});
        // unknown index, must leave everything unchanged
        write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), {$urandom, $urandom});
        cfg_valid   <= 1'b0;
        cfg_pat_lo  = lo;
        cfg_pat_hi  = hi;
        cfg_pat_len = len;
        cfg_limit   = limit;
    endtask

    // One buffer of random text, often with the live pattern planted in it
    task automatic feed_random_buffer(input bit brief);
        logic [7:0] text [$];
        int         n;
        int         len;
        int         at;
        t_in        item;
        t_out       no_res;
        no_res = '0;
        n = brief ? $urandom_range(1, 3) : $urandom_range(1, 24);
        for (int k = 0; k < n; k++) text.push_back(random_text_byte());
        len = live_length();
        if (!brief && len > 0 && $urandom_range(0, 9) < 6) begin
            at = $urandom_range(0, n);
            for (int m = 0; m < len; m++) begin
                if (at + m < text.size()) text[at+m] = pattern_at(m);
                else text.push_back(pattern_at(m));
            end
        end
        for (int k = 0; k < text.size(); k++) begin
            item.data_byte = text[k];
            if (k == 0) item.first_of_buffer = ($urandom_range(0, 15) != 0);
            else item.first_of_buffer = ($urandom_range(0, 40) == 0);
            if (k == text.size() - 1) item.end_of_buffer = ($urandom_range(0, 3) != 0);
            else item.end_of_buffer = ($urandom_range(0, 20) == 0);
            feed_byte(item, 1'b0, no_res);
        end
    endtask

    function automatic t_row setup_row(input logic [63:0] lo, input logic [63:0] hi,
                                       input logic [4:0] len, input logic [15:0] limit);
        t_row r;
        r = '0;
        r.kind    = ROW_SETUP;
        r.pat_lo  = lo;
        r.pat_hi  = hi;
        r.pat_len = len;
        r.limit   = limit;
        return r;
    endfunction

    function automatic t_row byte_row(input logic [7:0] data, input logic first, input logic last);
        t_row r;
        r = '0;
        r.kind = ROW_BYTE;
        r.item.data_byte       = data;
        r.item.first_of_buffer = first;
        r.item.end_of_buffer   = last;
        return r;
    endfunction

    function automatic t_row known_row(input logic [7:0] data, input logic first,
                                       input logic last, input logic found,
                                       input logic [OFFSET_BITS-1:0] offset);
        t_row r;
        r = byte_row(data, first, last);
        r.typed = 1'b1;
        r.want.match_found  = found;
        r.want.match_offset = offset;
        return r;
    endfunction

    // Result side: random ready gaps, plus one long hold on request
    initial begin : result_sink
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            gap = quiet_idle ? 0 : $urandom_range(0, GAP_MAX);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                gap = gap + RX_HOLD_CYCLES;
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk) begin
        t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (match_queue.size() == 0) begin
                report_mismatch($sformatf("unexpected result found=%0b offset=%0d",
                                          out_item.match_found, out_item.match_offset));
            end else begin
                want = match_queue.pop_front();
                if (out_item.match_found !== want.match_found)
                    report_mismatch($sformatf("match_found %b, expected %b",
                                              out_item.match_found, want.match_found));
                if (out_item.match_offset !== want.match_offset)
                    report_mismatch($sformatf("match_offset %0d, expected %0d",
                                              out_item.match_offset, want.match_offset));
            end
        end
    end

    // Watchdog: too long without any transfer on any channel
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus: reset, directed script, then random phases
    initial begin : stimulus
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  len;
        logic [15:0] limit;
        int          target;

        cfg_pat_lo    = '0;
        cfg_pat_hi    = '0;
        cfg_pat_len   = '0;
        cfg_limit     = LIMIT_RESET;
        recent        = '{default: 8'h00};
        position      = '0;
        buffer_closed = 1'b0;

        // empty pattern after reset, no first flag: first byte matches at 0
        script.push_back(known_row(8'h41, 1'b0, 1'b0, 1'b1, '0));
        script.push_back(byte_row(8'h42, 1'b0, 1'b1));
        // "ABC", partial match then a real one
        script.push_back(setup_row(64'h0043_4241, '0, 5'd3, LIMIT_RESET));
        script.push_back(byte_row(8'h41, 1'b1, 1'b0));
        script.push_back(byte_row(8'h41, 1'b0, 1'b0));
        script.push_back(byte_row(8'h42, 1'b0, 1'b0));
        script.push_back(byte_row(8'h43, 1'b0, 1'b0));
        // zero byte and end of buffer both close without a match
        script.push_back(byte_row(8'h58, 1'b1, 1'b0));
        script.push_back(known_row(8'h00, 1'b0, 1'b0, 1'b0, '0));
        script.push_back(known_row(8'h41, 1'b1, 1'b1, 1'b0, '0));
        // limit reached before the pattern fits
        script.push_back(setup_row(64'h0043_4241, '0, 5'd3, 16'd3));
        script.push_back(byte_row(8'h58, 1'b1, 1'b0));
        script.push_back(byte_row(8'h41, 1'b0, 1'b0));
        script.push_back(known_row(8'h42, 1'b0, 1'b0, 1'b0, '0));
        // zero limit makes the pattern empty
        script.push_back(setup_row(64'h0043_4241, '0, 5'd3, 16'd0));
        script.push_back(known_row(8'hFF, 1'b1, 1'b1, 1'b1, '0));
        // oversize length, pattern cut at its zero byte
        script.push_back(setup_row(64'hFFFF, '1, 5'd31, LIMIT_RESET));
        script.push_back(byte_row(8'hFF, 1'b1, 1'b0));
        script.push_back(known_row(8'hFF, 1'b0, 1'b0, 1'b1, '0));
        // match ending exactly on the limit, then a restart mid-search
        script.push_back(setup_row(64'h4241, '0, 5'd2, 16'd3));
        script.push_back(byte_row(8'h58, 1'b1, 1'b0));
        script.push_back(byte_row(8'h41, 1'b0, 1'b0));
        script.push_back(byte_row(8'h42, 1'b0, 1'b0));
        script.push_back(byte_row(8'h41, 1'b1, 1'b0));
        script.push_back(byte_row(8'h41, 1'b1, 1'b0));
        script.push_back(byte_row(8'h42, 1'b0, 1'b0));
        script.push_back(known_row(8'h00, 1'b1, 1'b1, 1'b0, '0));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[r]) begin
            if (script[r].kind == ROW_SETUP)
                program_search(script[r].pat_lo, script[r].pat_hi,
                               script[r].pat_len, script[r].limit);
            else
                feed_byte(script[r].item, script[r].typed, script[r].want);
        end

        // Random phases, each with its own setting; some are fixed extremes
        for (int phase = 0; phase < PHASES; phase++) begin
            for (int m = 0; m < 8; m++) begin
                lo[m*8 +: 8] = random_text_byte();
                hi[m*8 +: 8] = random_text_byte();
            end
            case (phase)
                0:       len = 5'd16;
                1:       len = 5'd31;
                2:       len = 5'd0;
                default: len = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                           : 5'($urandom_range(1, 5));
            endcase
            case (phase)
                0, 6:    limit = LIMIT_RESET;
                1:       limit = 16'd16;
                3:       limit = 16'd0;
                5:       limit = 16'd1;
                default: limit = ($urandom_range(0, 1) == 0) ? LIMIT_RESET
                                                             : 16'($urandom_range(1, 40));
            endcase
            program_search(lo, hi, len, limit);
            quiet_idle = (phase % 3 == 2);
            // short closed buffers pile up results while the sink holds off
            if (phase == PRESSURE_PHASE) rx_hold_req = 1'b1;
            target = sent_bytes + PHASE_BYTES;
            while (sent_bytes < target) feed_random_buffer(phase == PRESSURE_PHASE);
        end

        in_valid <= 1'b0;
        while (match_queue.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
src/bss_pkg.sv
src/bss_cell.sv
src/bss_prep.sv
src/bounded_substring_search.sv
src/bss_checker.sv
sim/tb_bounded_substring_search.sv
